>>> rtl/core/rcca_pkg.sv
package rcca_pkg;

  localparam int MAX_SYMBOLS_DEF = 64;
  localparam int VALUE_BITS_DEF  = 64;

  localparam int VALUE_W     = 64;
  localparam int SYM_W       = 8;
  localparam int CHAR_CNT_W  = 7;

  localparam int CFG_REGS    = 8;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 4;
  localparam int REG_SEL_W   = $clog2(CFG_REGS);

  localparam int ALPHA_BYTES = CFG_REGS * CFG_W / SYM_W;
  localparam int ALPHA_IDX_W = $clog2(ALPHA_BYTES);

  localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CHAR_NUL   = 8'h00;
  localparam int               MIN_RADIX  = 2;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CHECK,
    B_DIV,
    B_RD,
    B_LOAD,
    B_FAIL
  } back_state_t;

  typedef struct packed {
    logic done;
    logic ok;
  } chk_res_t;

endpackage

>>> rtl/core/rcca_in_if.sv
interface rcca_in_if;
  import rcca_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value_bits;
  logic               is_signed;

  modport source (output valid, value_bits, is_signed, input ready);
  modport sink   (input valid, value_bits, is_signed, output ready);
endinterface

>>> rtl/core/rcca_out_if.sv
interface rcca_out_if;
  import rcca_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [SYM_W-1:0]      symbol;
  logic                  minus_first;
  logic                  is_last;
  logic                  base_invalid;
  logic [CHAR_CNT_W-1:0] char_count;

  modport source (output valid, symbol, minus_first, is_last, base_invalid, char_count,
                  input ready);
  modport sink   (input valid, symbol, minus_first, is_last, base_invalid, char_count,
                  output ready);
endinterface

>>> rtl/core/radix_convert_custom_alphabet.sv
// Channel   Dir  Handshake         Payload
// in_ch     in   valid/ready       value_bits[63:0], is_signed
// out_ch    out  valid/ready       symbol[7:0], minus_first, is_last, base_invalid,
//                                  char_count[6:0]
// cfg_*     in   cfg_we (no wait)  cfg_index[3:0], cfg_wdata[63:0]
//
// Per transaction: the queue is popped, the alphabet is scanned up to the terminator
// (or the first offending symbol), the bit-serial divider divides the whole value once
// per digit, then each digit is read from the stack and loaded into the output register.
// The divider dominates the worst case, which at 64 bits is radix 2.
// An invalid alphabet costs the pop, the scan to the offending symbol and one output load.
// A two-entry queue takes new transactions while the divider works; the output
// register stalls only the back end. rst_n is synchronous and clears the control and alphabet registers.
module radix_convert_custom_alphabet #(
  parameter int MAX_SYMBOLS = rcca_pkg::MAX_SYMBOLS_DEF,
  parameter int VALUE_BITS  = rcca_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rcca_in_if.sink                        in_ch,
  rcca_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [rcca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcca_pkg::CFG_W-1:0]     cfg_wdata
);
  import rcca_pkg::*;

  logic                         q_valid;
  logic                         q_neg;
  logic [VALUE_BITS-1:0]        q_mag;
  logic                         q_pop;
  logic                         chk_start;
  chk_res_t                     chk;
  logic [$clog2(MAX_SYMBOLS):0] radix;
  logic [ALPHA_IDX_W-1:0]       lk_idx;
  logic [SYM_W-1:0]             lk_sym;

  rcca_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_neg   (q_neg),
    .q_mag   (q_mag),
    .q_pop   (q_pop)
  );

  rcca_alpha #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_alpha (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .chk_start (chk_start),
    .chk       (chk),
    .radix     (radix),
    .lk_idx    (lk_idx),
    .lk_sym    (lk_sym)
  );

  rcca_back #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_neg     (q_neg),
    .q_mag     (q_mag),
    .q_pop     (q_pop),
    .chk_start (chk_start),
    .chk       (chk),
    .radix     (radix),
    .lk_idx    (lk_idx),
    .lk_sym    (lk_sym),
    .out_ch    (out_ch)
  );

endmodule

>>> rtl/core/rcca_front.sv
module rcca_front #(
  parameter int VALUE_BITS = rcca_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rcca_in_if.sink               in_ch,
  output logic                  q_valid,
  output logic                  q_neg,
  output logic [VALUE_BITS-1:0] q_mag,
  input  logic                  q_pop
);
  import rcca_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);

  logic [VALUE_BITS-1:0] raw;
  logic                  neg;
  logic [VALUE_BITS-1:0] mag;
  logic                  push;

  logic [VALUE_BITS-1:0] q_mag_r [QUEUE_DEPTH];
  logic                  q_neg_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [QC_W-1:0]       q_cnt_r;

  // magnitude of the most negative value wraps onto itself, which is what we want
  always_comb begin
    raw = in_ch.value_bits[VALUE_BITS-1:0];
    neg = in_ch.is_signed & raw[VALUE_BITS-1];
    mag = neg ? (~raw + VALUE_BITS'(1)) : raw;
  end

  assign in_ch.ready = (q_cnt_r != QC_W'(QUEUE_DEPTH));
  assign push        = in_ch.valid & in_ch.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mag_r[wr_ptr_r] <= mag;
      q_neg_r[wr_ptr_r] <= neg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      if (push)  wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (q_pop) rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      if (push && !q_pop)      q_cnt_r <= q_cnt_r + QC_W'(1);
      else if (!push && q_pop) q_cnt_r <= q_cnt_r - QC_W'(1);
    end
  end

  assign q_valid = (q_cnt_r != '0);
  assign q_mag   = q_mag_r[rd_ptr_r];
  assign q_neg   = q_neg_r[rd_ptr_r];

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= QC_W'(QUEUE_DEPTH))
    else $error("queue count overflow");

  a_neg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && q_neg |-> q_mag != '0)
    else $error("negative entry with zero magnitude");

endmodule

>>> rtl/core/rcca_alpha.sv
module rcca_alpha #(
  parameter int MAX_SYMBOLS = rcca_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [rcca_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rcca_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic                                  chk_start,
  output rcca_pkg::chk_res_t                    chk,
  output logic [$clog2(MAX_SYMBOLS):0]          radix,
  input  logic [rcca_pkg::ALPHA_IDX_W-1:0]      lk_idx,
  output logic [rcca_pkg::SYM_W-1:0]            lk_sym
);
  import rcca_pkg::*;

  localparam int KW    = $clog2(MAX_SYMBOLS + 1);
  localparam int RAD_W = $clog2(MAX_SYMBOLS) + 1;

  logic [CFG_W-1:0] sym_r [CFG_REGS];
  logic [SYM_W-1:0] sym_b [ALPHA_BYTES];

  logic             busy_r;
  logic [KW-1:0]    k_r;
  logic [SYM_W-1:0] cur;
  logic             dup;
  logic             at_end;
  logic             bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CFG_REGS; i++) sym_r[i] <= '0;
    end else if (cfg_we && cfg_index < CFG_IDX_W'(CFG_REGS)) begin
      sym_r[cfg_index[REG_SEL_W-1:0]] <= cfg_wdata;
    end
  end

  always_comb begin
    for (int i = 0; i < ALPHA_BYTES; i++) begin
      sym_b[i] = sym_r[i >> 3][(i & 7) * SYM_W +: SYM_W];
    end
  end

  assign lk_sym = sym_b[lk_idx];

  // one symbol per cycle, compared against every earlier symbol at once
  always_comb begin
    cur = sym_b[ALPHA_IDX_W'(k_r)];
    dup = 1'b0;
    for (int j = 0; j < MAX_SYMBOLS; j++) begin
      if (KW'(j) < k_r && sym_b[j] == cur) dup = 1'b1;
    end
    at_end   = (k_r == KW'(MAX_SYMBOLS)) || (cur == CHAR_NUL);
    bad      = (cur == CHAR_PLUS) || (cur == CHAR_MINUS) || dup;
    chk.done = busy_r && (at_end || bad);
    chk.ok   = at_end && (k_r >= KW'(MIN_RADIX));
    radix    = RAD_W'(k_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
    end else if (chk_start) begin
      busy_r <= 1'b1;
      k_r    <= '0;
    end else if (busy_r) begin
      if (chk.done) busy_r <= 1'b0;
      else          k_r    <= k_r + KW'(1);
    end
  end

  a_radix_range: assert property (@(posedge clk) disable iff (!rst_n)
    chk.done && chk.ok |-> radix >= RAD_W'(MIN_RADIX) && radix <= RAD_W'(MAX_SYMBOLS))
    else $error("accepted alphabet with radix out of range");

endmodule

>>> rtl/core/rcca_back.sv
module rcca_back #(
  parameter int MAX_SYMBOLS = rcca_pkg::MAX_SYMBOLS_DEF,
  parameter int VALUE_BITS  = rcca_pkg::VALUE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_valid,
  input  logic                                  q_neg,
  input  logic [VALUE_BITS-1:0]                 q_mag,
  output logic                                  q_pop,
  output logic                                  chk_start,
  input  rcca_pkg::chk_res_t                    chk,
  input  logic [$clog2(MAX_SYMBOLS):0]          radix,
  output logic [rcca_pkg::ALPHA_IDX_W-1:0]      lk_idx,
  input  logic [rcca_pkg::SYM_W-1:0]            lk_sym,
  rcca_out_if.source                            out_ch
);
  import rcca_pkg::*;

  localparam int DIG_W  = $clog2(MAX_SYMBOLS);
  localparam int RAD_W  = DIG_W + 1;
  localparam int AW     = $clog2(VALUE_BITS);
  localparam int CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int STEP_W = $clog2(VALUE_BITS);

  back_state_t state_r, state_nxt;

  logic [VALUE_BITS-1:0] quo_r, quo_nxt;
  logic [DIG_W-1:0]      rem_r, rem_nxt;
  logic [RAD_W-1:0]      radix_r, radix_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic                  first_r, first_nxt;
  logic                  neg_r, neg_nxt;

  logic                  ov_r, ov_nxt;
  logic [SYM_W-1:0]      sym_r, sym_nxt;
  logic                  minus_r, minus_nxt;
  logic                  last_r, last_nxt;
  logic                  inv_r, inv_nxt;
  logic [CHAR_CNT_W-1:0] cc_r, cc_nxt;

  logic [DIG_W:0]        trial;
  logic [DIG_W:0]        diff;
  logic                  ge;
  logic [DIG_W-1:0]      div_rem;
  logic [VALUE_BITS-1:0] div_quo;
  logic                  load_ok;
  logic                  st_we, st_re;

  logic [DIG_W-1:0]      stack [VALUE_BITS];
  logic [DIG_W-1:0]      st_rd_r;

  // restoring divider, one quotient bit per cycle; quotient shifts in behind the dividend
  always_comb begin
    trial   = {rem_r, quo_r[VALUE_BITS-1]};
    ge      = (trial >= radix_r);
    diff    = trial - radix_r;
    div_rem = ge ? diff[DIG_W-1:0] : trial[DIG_W-1:0];
    div_quo = {quo_r[VALUE_BITS-2:0], ge};
  end

  assign load_ok = !ov_r || out_ch.ready;
  assign lk_idx  = ALPHA_IDX_W'(st_rd_r);

  always_comb begin
    state_nxt = state_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    radix_nxt = radix_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    first_nxt = first_r;
    neg_nxt   = neg_r;
    ov_nxt    = ov_r;
    sym_nxt   = sym_r;
    minus_nxt = minus_r;
    last_nxt  = last_r;
    inv_nxt   = inv_r;
    cc_nxt    = cc_r;
    q_pop     = 1'b0;
    chk_start = 1'b0;
    st_we     = 1'b0;
    st_re     = 1'b0;

    if (ov_r && out_ch.ready) ov_nxt = 1'b0;

    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          chk_start = 1'b1;
          quo_nxt   = q_mag;
          neg_nxt   = q_neg;
          state_nxt = B_CHECK;
        end
      end
      B_CHECK: begin
        if (chk.done) begin
          radix_nxt = radix;
          rem_nxt   = '0;
          step_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = chk.ok ? B_DIV : B_FAIL;
        end
      end
      B_DIV: begin
        quo_nxt  = div_quo;
        rem_nxt  = div_rem;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(VALUE_BITS - 1)) begin
          // digit done: push remainder, restart on the quotient
          st_we    = 1'b1;
          cnt_nxt  = cnt_r + CNT_W'(1);
          step_nxt = '0;
          rem_nxt  = '0;
          if (div_quo == '0) begin
            idx_nxt   = cnt_r[AW-1:0];
            first_nxt = 1'b1;
            state_nxt = B_RD;
          end
        end
      end
      B_RD: begin
        st_re     = 1'b1;
        state_nxt = B_LOAD;
      end
      B_LOAD: begin
        if (load_ok) begin
          ov_nxt    = 1'b1;
          sym_nxt   = lk_sym;
          minus_nxt = first_r & neg_r;
          last_nxt  = (idx_r == '0);
          inv_nxt   = 1'b0;
          cc_nxt    = (idx_r == '0) ? (CHAR_CNT_W'(cnt_r) + CHAR_CNT_W'(neg_r)) : '0;
          first_nxt = 1'b0;
          if (idx_r == '0) begin
            state_nxt = B_IDLE;
          end else begin
            idx_nxt   = idx_r - AW'(1);
            state_nxt = B_RD;
          end
        end
      end
      B_FAIL: begin
        if (load_ok) begin
          ov_nxt    = 1'b1;
          sym_nxt   = CHAR_NUL;
          minus_nxt = 1'b0;
          last_nxt  = 1'b1;
          inv_nxt   = 1'b1;
          cc_nxt    = '0;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      ov_r  <= ov_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    radix_r <= radix_nxt;
    step_r  <= step_nxt;
    idx_r   <= idx_nxt;
    first_r <= first_nxt;
    neg_r   <= neg_nxt;
    sym_r   <= sym_nxt;
    minus_r <= minus_nxt;
    last_r  <= last_nxt;
    inv_r   <= inv_nxt;
    cc_r    <= cc_nxt;
  end

  // digit stack, written during division and read back in reverse
  always_ff @(posedge clk) begin
    if (st_we) stack[cnt_r[AW-1:0]] <= div_rem;
    if (st_re) st_rd_r <= stack[idx_r];
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.symbol       = sym_r;
  assign out_ch.minus_first  = minus_r;
  assign out_ch.is_last      = last_r;
  assign out_ch.base_invalid = inv_r;
  assign out_ch.char_count   = cc_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_DIV |-> cnt_r < CNT_W'(VALUE_BITS))
    else $error("digit count overran the stack");

  a_invalid_shape: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && inv_r |-> last_r && cc_r == '0 && sym_r == CHAR_NUL)
    else $error("malformed invalid-alphabet result");

  a_last_count: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && last_r && !inv_r |-> cc_r != '0)
    else $error("final digit with zero character count");

endmodule
